@@ src/obl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_pkg: shared definitions for the order book level table
// Table size, index widths and result outcome codes.
// ----------------------------------------------------------------------------
package obl_pkg;

	// Number of price levels kept for each book side.
	localparam int LEVELS_PER_SIDE = 64;

	// Slot index width, and the padded row count of one side in the price RAM.
	localparam int IDX_W     = $clog2(LEVELS_PER_SIDE);
	localparam int SIDE_ROWS = 2 ** IDX_W;

	// Field widths of the items.
	localparam int PRICE_W   = 32;
	localparam int QTY_W     = 48;
	localparam int OUTCOME_W = 3;

	// Outcome of one update item.
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_UPDATED  = 3'd0,
		OUT_REMOVED  = 3'd1,
		OUT_INSERTED = 3'd2,
		OUT_IGNORED  = 3'd3,
		OUT_DROPPED  = 3'd4
	} outcome_t;

endpackage
`default_nettype wire

@@ src/order_book_level_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// order_book_level_update: bid and ask price level tables
// Applies one price level update per item to the chosen side of the book.
//
// An input item on the s_ channel carries the side in s_tuser and the price
// and quantity in s_tdata. The block scans that side's table one slot per
// cycle through the price RAM read port and a single 32-bit price comparator,
// looking for the first valid slot holding the price and the first free slot.
// It then updates, removes or inserts the level, or leaves the table as it
// is when the item is ignored or dropped, and presents one result item on
// the m_ channel: the outcome code in m_tdata and the changed flag in m_tuser.
// A result is presented after the slot-by-slot scan, a drain step for the
// registered read and a decide step. s_tready is low from acceptance until
// the result is loaded into the output register and rises in the same cycle
// as the result is presented, so no new item is taken before that.
// A result waits in an output register, and the next item is accepted while
// it waits. If the receiver stalls for longer than a whole scan, the finished
// item waits at the end of its scan until the output register is free.
// Reset clears every valid mark, so both tables start empty; no clearing
// pass is needed and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module order_book_level_update (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Update items in.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // [31:0] price, [79:32] quantity
	input  wire logic        s_tuser,   // [0] side
	// Results out.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,   // [2:0] outcome, [7:3] zero
	output logic             m_tuser    // [0] changed
);

	localparam int IDX_W = obl_pkg::IDX_W;
	localparam int ADDR_W = IDX_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	state_t                           state_q;
	logic                             side_q;
	logic [obl_pkg::PRICE_W-1:0]      price_q;
	logic                             qty_nz_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [IDX_W-1:0]                 idx_s1;
	logic                             rd_valid_s1;
	logic                             hit_found_q;
	logic [IDX_W-1:0]                 hit_idx_q;
	logic                             free_found_q;
	logic [IDX_W-1:0]                 free_idx_q;
	logic [obl_pkg::LEVELS_PER_SIDE-1:0] valid_q [2];
	logic                             m_tvalid_q;
	obl_pkg::outcome_t                outcome_q;
	logic                             changed_q;

	logic                             out_free;
	logic                             slot_valid;
	logic                             price_eq;
	logic                             ram_we;
	logic [ADDR_W-1:0]                ram_waddr;
	logic [ADDR_W-1:0]                ram_raddr;
	logic [obl_pkg::PRICE_W-1:0]      ram_rdata;
	obl_pkg::outcome_t                outcome_d;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Price store for both sides, the side picking the upper address half.
	assign ram_raddr = {side_q, idx_q};
	assign ram_waddr = {side_q, free_idx_q};

	obl_ram #(
		.WIDTH (obl_pkg::PRICE_W),
		.DEPTH (2 * obl_pkg::SIDE_ROWS)
	) u_price_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (price_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Compare of the slot read in the previous cycle against the wanted price.
	assign slot_valid = valid_q[side_q][idx_s1];
	assign price_eq   = (ram_rdata == price_q);

	// Outcome once the scan is complete.
	always_comb begin
		if (hit_found_q) begin
			outcome_d = qty_nz_q ? obl_pkg::OUT_UPDATED : obl_pkg::OUT_REMOVED;
		end else if (!qty_nz_q) begin
			outcome_d = obl_pkg::OUT_IGNORED;
		end else if (!free_found_q) begin
			outcome_d = obl_pkg::OUT_DROPPED;
		end else begin
			outcome_d = obl_pkg::OUT_INSERTED;
		end
	end

	// A new price is written into the free slot only on an insert.
	assign ram_we = (state_q == ST_DECIDE) && out_free
		&& (outcome_d == obl_pkg::OUT_INSERTED);

	// Sequencer, scan trackers, valid marks and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_valid_s1  <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			valid_q[0]   <= '0;
			valid_q[1]   <= '0;
		end else begin
			// The result register is loaded when a finished item leaves and
			// cleared once the receiver has taken it.
			if ((state_q == ST_DECIDE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// Track the first matching slot and the first free slot.
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (rd_valid_s1) begin
				if (slot_valid) begin
					if (!hit_found_q && price_eq) begin
						hit_found_q <= 1'b1;
						hit_idx_q   <= idx_s1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						side_q       <= s_tuser;
						price_q      <= s_tdata[31:0];
						qty_nz_q     <= (s_tdata[79:32] != '0);
						idx_q        <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_s1 <= idx_q;
					if (idx_q == IDX_W'(obl_pkg::LEVELS_PER_SIDE - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (outcome_d == obl_pkg::OUT_REMOVED) begin
							valid_q[side_q][hit_idx_q] <= 1'b0;
						end else if (outcome_d == obl_pkg::OUT_INSERTED) begin
							valid_q[side_q][free_idx_q] <= 1'b1;
						end
						outcome_q  <= outcome_d;
						changed_q  <= (outcome_d == obl_pkg::OUT_UPDATED)
							|| (outcome_d == obl_pkg::OUT_REMOVED)
							|| (outcome_d == obl_pkg::OUT_INSERTED);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, outcome_q};
	assign m_tuser  = changed_q;

endmodule
`default_nettype wire

@@ src/obl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module obl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write first in code order; a read of the address being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ src/obl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_checker: port checks for the order book level table
// Watches the top level's ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module obl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tuser
);

	// The changed flag is set exactly for updates, removals and inserts.
	a_changed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ((m_tdata[2:0] == 3'(obl_pkg::OUT_UPDATED))
			|| (m_tdata[2:0] == 3'(obl_pkg::OUT_REMOVED))
			|| (m_tdata[2:0] == 3'(obl_pkg::OUT_INSERTED)))))
		else $error("changed flag does not match outcome");

	// Only defined outcome codes appear, with the padding bits zero.
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[7:3] == 5'd0) && (m_tdata[2:0] <= 3'(obl_pkg::OUT_DROPPED))))
		else $error("undefined outcome code");

	// An accepted item starts a scan, so the input is not ready next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready while scanning");

	// A result held by the receiver stays unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind order_book_level_update obl_checker u_obl_checker (.*);
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for order_book_level_update
// Drives price level updates into the bid and ask tables and checks each
// result against an in-bench copy of both tables. A short table of opening
// updates comes first. Whole-side fills, mixed traffic and dense traffic on
// small price sets follow, with random idling on both sides but in the dense run.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LEVELS_PER_SIDE = obl_pkg::LEVELS_PER_SIDE;
	localparam int PRICE_W         = obl_pkg::PRICE_W;
	localparam int QTY_W           = obl_pkg::QTY_W;

	// Book sides as carried in s_tuser.
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
	localparam logic [QTY_W-1:0]   QTY_MAX   = '1;

	// One opening update; the outcome is given only where the row is marked typed.
	typedef struct packed {
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
		bit                 typed;
		obl_pkg::outcome_t  outcome;
		logic               changed;
	} opening_row_t;

	typedef struct packed {
		obl_pkg::outcome_t outcome;
		logic              changed;
	} level_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;    // [31:0] price, [79:32] quantity
	logic        s_tuser  = 1'b0;  // [0] side
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [2:0] outcome, [7:3] zero
	logic        m_tuser;          // [0] changed

	// Shadow copy of both tables, indexed by side.
	logic [PRICE_W-1:0] book_price [2][LEVELS_PER_SIDE];
	logic [QTY_W-1:0]   book_qty   [2][LEVELS_PER_SIDE];
	bit                 book_live  [2][LEVELS_PER_SIDE];

	level_result_t      pending_results [$];
	logic [PRICE_W-1:0] price_base [2];
	int                 mismatch_count = 0;
	int                 hold_cycles    = 0;
	bit                 steady_run     = 1'b0;

	// Opening updates on empty tables: extremes of price and quantity,
	// zero for an absent level, same-quantity update, removal and slot reuse.
	opening_row_t opening_rows [16] = '{
		'{SIDE_BID, 32'h0000_0000, 48'h0,              1'b1, obl_pkg::OUT_IGNORED,  1'b0},
		'{SIDE_ASK, PRICE_MAX,     48'h0,              1'b1, obl_pkg::OUT_IGNORED,  1'b0},
		'{SIDE_BID, 32'h0000_0000, QTY_MAX,            1'b1, obl_pkg::OUT_INSERTED, 1'b1},
		'{SIDE_ASK, PRICE_MAX,     48'h1,              1'b1, obl_pkg::OUT_INSERTED, 1'b1},
		'{SIDE_BID, 32'h0000_0000, QTY_MAX,            1'b1, obl_pkg::OUT_UPDATED,  1'b1},
		'{SIDE_BID, PRICE_MAX,     48'h1,              1'b1, obl_pkg::OUT_INSERTED, 1'b1},
		'{SIDE_ASK, 32'h0000_0000, 48'h5555_5555_5555, 1'b1, obl_pkg::OUT_INSERTED, 1'b1},
		'{SIDE_BID, 32'h0000_0000, 48'h0,              1'b1, obl_pkg::OUT_REMOVED,  1'b1},
		'{SIDE_BID, 32'hA5A5_A5A5, 48'hAAAA_AAAA_AAAA, 1'b1, obl_pkg::OUT_INSERTED, 1'b1},
		'{SIDE_BID, 32'h0000_0000, 48'h0,              1'b1, obl_pkg::OUT_IGNORED,  1'b0},
		'{SIDE_ASK, PRICE_MAX,     48'h8000_0000_0000, 1'b0, obl_pkg::OUT_UPDATED,  1'b0},
		'{SIDE_ASK, 32'h5A5A_5A5A, 48'h0,              1'b0, obl_pkg::OUT_UPDATED,  1'b0},
		'{SIDE_BID, PRICE_MAX,     48'h0,              1'b0, obl_pkg::OUT_UPDATED,  1'b0},
		'{SIDE_BID, 32'hA5A5_A5A5, 48'h7,              1'b0, obl_pkg::OUT_UPDATED,  1'b0},
		'{SIDE_ASK, 32'h0000_0000, 48'h0,              1'b0, obl_pkg::OUT_UPDATED,  1'b0},
		'{SIDE_ASK, PRICE_MAX,     48'h0,              1'b0, obl_pkg::OUT_UPDATED,  1'b0}
	};

	order_book_level_update DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one update to the shadow tables and returns its outcome.
	function automatic obl_pkg::outcome_t apply_level_update(input logic side,
			input logic [PRICE_W-1:0] price, input logic [QTY_W-1:0] qty);
		int hit;
		int free_slot;
		hit       = -1;
		free_slot = -1;
		for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
			if (book_live[side][i]) begin
				if (hit < 0 && book_price[side][i] == price)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (hit >= 0) begin
			if (qty != '0) begin
				book_qty[side][hit] = qty;
				return obl_pkg::OUT_UPDATED;
			end
			book_live[side][hit] = 1'b0;
			return obl_pkg::OUT_REMOVED;
		end
		if (qty == '0)
			return obl_pkg::OUT_IGNORED;
		if (free_slot < 0)
			return obl_pkg::OUT_DROPPED;
		book_price[side][free_slot] = price;
		book_qty[side][free_slot]   = qty;
		book_live[side][free_slot]  = 1'b1;
		return obl_pkg::OUT_INSERTED;
	endfunction

	// Quantity with weight on the extremes and on small values.
	function automatic logic [QTY_W-1:0] random_quantity();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return QTY_W'(1);
			1: return QTY_MAX;
			2: return QTY_W'(raw[15:0]);
			default: return raw[QTY_W-1:0];
		endcase
	endfunction

	// Offers one update item, waits for acceptance and records its expected result.
	task automatic send_update(input logic side, input logic [PRICE_W-1:0] price,
			input logic [QTY_W-1:0] qty, input bit typed,
			input obl_pkg::outcome_t typed_outcome, input logic typed_changed);
		obl_pkg::outcome_t outcome;
		level_result_t     want;
		if (!steady_run && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {qty, price};
		s_tuser  <= side;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		outcome = apply_level_update(side, price, qty);
		if (typed) begin
			want.outcome = typed_outcome;
			want.changed = typed_changed;
		end else begin
			want.outcome = outcome;
			want.changed = (outcome <= obl_pkg::OUT_INSERTED);
		end
		pending_results.insert(pending_results.size(), want);
	endtask

	// Distinct nonzero levels from base upwards; past the table size they are dropped.
	task automatic fill_side(input logic side, input int count);
		logic [QTY_W-1:0] qty;
		for (int i = 0; i < count; i++) begin
			qty = random_quantity();
			if (qty == '0)
				qty = QTY_W'(1);
			send_update(side, price_base[side] + PRICE_W'(i), qty, 1'b0,
				obl_pkg::OUT_UPDATED, 1'b0);
		end
	endtask

	// Updates on both sides drawn from a set of prices near each side's base,
	// with some prices taken from the whole range.
	task automatic run_mixed(input int count, input int pool, input int zero_pct);
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
		repeat (count) begin
			side = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 99) < 12)
				price = $urandom;
			else
				price = price_base[side] + $urandom_range(0, pool - 1);
			qty = ($urandom_range(0, 99) < zero_pct) ? '0 : random_quantity();
			send_update(side, price, qty, 1'b0, obl_pkg::OUT_UPDATED, 1'b0);
		end
	endtask

	// Result side: long hold-offs on request, otherwise short random stalls.
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (!steady_run && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Each result is matched against the oldest expected one.
	always @(posedge clk) begin : result_check
		level_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: outcome %0d changed %0d",
					$time, m_tdata[2:0], m_tuser);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[2:0] !== want.outcome) begin
					$display("%0t: outcome expected %0d, actual %0d",
						$time, want.outcome, m_tdata[2:0]);
					mismatch_count++;
				end
				if (m_tuser !== want.changed) begin
					$display("%0t: changed expected %0d, actual %0d",
						$time, want.changed, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus sequence and end of run.
	initial begin
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
				book_price[s][i] = '0;
				book_qty[s][i]   = '0;
				book_live[s][i]  = 1'b0;
			end
		price_base[SIDE_BID] = $urandom;
		price_base[SIDE_ASK] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[r])
			send_update(opening_rows[r].side, opening_rows[r].price, opening_rows[r].qty,
				opening_rows[r].typed, opening_rows[r].outcome, opening_rows[r].changed);

		// Fill the bid side past its capacity, then churn near a full table.
		fill_side(SIDE_BID, LEVELS_PER_SIDE + 2);
		run_mixed(150, LEVELS_PER_SIDE + 6, 30);

		// Sender waits for the block to drain, then fills the ask side while
		// the receiver holds off long enough for the input to stall.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		hold_cycles = 300;
		fill_side(SIDE_ASK, LEVELS_PER_SIDE + 2);

		// Dense traffic on a few prices per side, with no idling.
		steady_run = 1'b1;
		run_mixed(200, 8, 35);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * LEVELS_PER_SIDE) @(posedge clk);
		if (mismatch_count == 0)
			$display("order_book_level_update verification clean");
		else
			$display("order_book_level_update verification failed");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("order_book_level_update verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/obl_pkg.sv
src/obl_ram.sv
src/order_book_level_update.sv
src/obl_checker.sv
test/testbench.sv
